// ===== src/btdo_pkg.sv =====
// ----------------------------------------------------------------------------
// btdo_pkg
// shared constants for the bilinear distortion offset table
// ----------------------------------------------------------------------------
package btdo_pkg;

   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;

   // mapped position and accumulator widths
   localparam int POS_W = 50;
   localparam int ACC_W = 68;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_INTERP = 1'b1;

   localparam logic [3:0] CSR_REF_COORD_X  = 4'd0;
   localparam logic [3:0] CSR_REF_COORD_Y  = 4'd1;
   localparam logic [3:0] CSR_INV_STEP_X   = 4'd2;
   localparam logic [3:0] CSR_INV_STEP_Y   = 4'd3;
   localparam logic [3:0] CSR_REF_INDEX_X  = 4'd4;
   localparam logic [3:0] CSR_REF_INDEX_Y  = 4'd5;
   localparam logic [3:0] CSR_TABLE_WIDTH  = 4'd6;
   localparam logic [3:0] CSR_TABLE_HEIGHT = 4'd7;

   localparam logic [31:0]      INV_STEP_RESET = 32'h0001_0000;
   localparam logic [6:0]       SIZE_RESET     = 7'd1;
   localparam logic [16:0]      Q16_ONE        = 17'h1_0000;
   localparam logic [ACC_W-1:0] ROUND_HALF     = ACC_W'(64'h0000_0000_8000_0000);
   localparam logic [31:0]      Q16_MAX        = 32'h7FFF_FFFF;
   localparam logic [31:0]      Q16_MIN        = 32'h8000_0000;

endpackage

// ===== src/bilinear_table_distortion_offset_core.sv =====
// ----------------------------------------------------------------------------
// bilinear_table_distortion_offset_core
// throughput: one word per cycle while rsp_stall lets the pipeline advance,
// set by the four parity banks, each with one read and one write port, so all
// four neighbours come out in one access
// reset clears the valids and the configuration; table entries are undefined
// until written, and there is no clearing pass
// ----------------------------------------------------------------------------
module bilinear_table_distortion_offset_core
   import btdo_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic [5:0]         req_entry_col,
   input  logic [5:0]         req_entry_row,
   input  logic signed [31:0] req_entry_value,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_offset,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int XW          = $clog2(MAX_WIDTH);
   localparam int YW          = $clog2(MAX_HEIGHT);
   localparam int HW          = (MAX_WIDTH + 1) / 2;
   localparam int HH          = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH  = HW * HH;
   localparam int AW          = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   // configuration
   logic [31:0] ref_coord_x_ff, ref_coord_y_ff;
   logic [31:0] inv_step_x_ff, inv_step_y_ff;
   logic [31:0] ref_index_x_ff, ref_index_y_ff;
   logic [6:0]  table_width_ff, table_height_ff;

   // flow control
   logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10, en_out;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic rsp_valid_ff;

   // write word carried down to the bank stage
   logic       op1_ff, op2_ff, op3_ff, op4_ff, op5_ff;
   logic [5:0] col1_ff, col2_ff, col3_ff, col4_ff, col5_ff;
   logic [5:0] row1_ff, row2_ff, row3_ff, row4_ff, row5_ff;
   logic [31:0] val1_ff, val2_ff, val3_ff, val4_ff, val5_ff;

   // axis mapping
   logic [32:0] diff_x_in, diff_y_in, mag_x_full, mag_y_full;
   logic        neg_x1_ff, neg_y1_ff, neg_x2_ff, neg_y2_ff;
   logic [31:0] mag_x1_ff, mag_y1_ff;
   logic [63:0] prod_x2_ff, prod_y2_ff;
   logic signed [64:0] sv_x_in, sv_y_in;
   logic [48:0] scaled_x3_ff, scaled_y3_ff;
   logic [POS_W-1:0] pos_x_in, pos_y_in, pos_x4_ff, pos_y4_ff;
   logic [POS_W-1:0] hi_x, hi_y, clamp_x, clamp_y;
   logic [31:0] eff_w, eff_h;
   logic [XW-1:0] last_x, cx5_ff, cx1;
   logic [YW-1:0] last_y, cy5_ff, cy1;
   logic [15:0] fx5_ff, fy5_ff;

   // bank access
   logic [31:0]   mem [4][BANK_DEPTH];
   logic [AW-1:0] raddr [4];
   logic [AW-1:0] waddr;
   logic [XW-1:0] wcol;
   logic [YW-1:0] wrow;
   logic [3:0]    wr_en;
   logic          wr_ok;
   logic [3:0][31:0] rd_ff;
   logic        sx0_ff, sx1_ff, sy0_ff, sy1_ff;
   logic [15:0] fx6_ff, fy6_ff;

   // weighting and sum
   logic [3:0][31:0]       e_in, e7_ff;
   logic [3:0][32:0]       w_in, w7_ff;
   logic [3:0][ACC_W-1:0]  p_in, p8_ff;
   logic [ACC_W-1:0]       s01_ff, s23_ff, acc_in, acc10_ff;
   logic [31:0]            offset_in, rsp_offset_ff;
   logic                   fits;

   assign csr_ready  = 1'b1;
   assign req_stall  = !en1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_offset = rsp_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_coord_x_ff  <= '0;
         ref_coord_y_ff  <= '0;
         inv_step_x_ff   <= INV_STEP_RESET;
         inv_step_y_ff   <= INV_STEP_RESET;
         ref_index_x_ff  <= '0;
         ref_index_y_ff  <= '0;
         table_width_ff  <= SIZE_RESET;
         table_height_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REF_COORD_X:  ref_coord_x_ff  <= csr_data;
            CSR_REF_COORD_Y:  ref_coord_y_ff  <= csr_data;
            CSR_INV_STEP_X:   inv_step_x_ff   <= csr_data;
            CSR_INV_STEP_Y:   inv_step_y_ff   <= csr_data;
            CSR_REF_INDEX_X:  ref_index_x_ff  <= csr_data;
            CSR_REF_INDEX_Y:  ref_index_y_ff  <= csr_data;
            CSR_TABLE_WIDTH:  table_width_ff  <= csr_data[6:0];
            CSR_TABLE_HEIGHT: table_height_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      en_out = !rsp_valid_ff || !rsp_stall;
      en10   = !v10_ff || en_out;
      en9    = !v9_ff  || en10;
      en8    = !v8_ff  || en9;
      en7    = !v7_ff  || en8;
      en6    = !v6_ff  || en7;
      en5    = !v5_ff  || en6;
      en4    = !v4_ff  || en5;
      en3    = !v3_ff  || en4;
      en2    = !v2_ff  || en3;
      en1    = !v1_ff  || en2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0; v8_ff <= 1'b0;
         v9_ff <= 1'b0; v10_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff  <= req_valid;
         if (en2)    v2_ff  <= v1_ff;
         if (en3)    v3_ff  <= v2_ff;
         if (en4)    v4_ff  <= v3_ff;
         if (en5)    v5_ff  <= v4_ff;
         if (en6)    v6_ff  <= v5_ff && (op5_ff == OP_INTERP);
         if (en7)    v7_ff  <= v6_ff;
         if (en8)    v8_ff  <= v7_ff;
         if (en9)    v9_ff  <= v8_ff;
         if (en10)   v10_ff <= v9_ff;
         if (en_out) rsp_valid_ff <= v10_ff;
      end
   end

   // coordinate minus reference, as sign and magnitude
   always_comb begin
      diff_x_in  = {req_coord_x[31], req_coord_x} - {ref_coord_x_ff[31], ref_coord_x_ff};
      diff_y_in  = {req_coord_y[31], req_coord_y} - {ref_coord_y_ff[31], ref_coord_y_ff};
      mag_x_full = diff_x_in[32] ? (33'd0 - diff_x_in) : diff_x_in;
      mag_y_full = diff_y_in[32] ? (33'd0 - diff_y_in) : diff_y_in;
   end

   always_comb begin
      sv_x_in  = neg_x2_ff ? -$signed({1'b0, prod_x2_ff}) : $signed({1'b0, prod_x2_ff});
      sv_y_in  = neg_y2_ff ? -$signed({1'b0, prod_y2_ff}) : $signed({1'b0, prod_y2_ff});
      pos_x_in = {scaled_x3_ff[48], scaled_x3_ff} + {{18{ref_index_x_ff[31]}}, ref_index_x_ff};
      pos_y_in = {scaled_y3_ff[48], scaled_y3_ff} + {{18{ref_index_y_ff[31]}}, ref_index_y_ff};
   end

   // sizes in use, clamped to the table; a zero size acts as one
   always_comb begin
      if (table_width_ff == 7'd0) begin
         eff_w = 32'd1;
      end else if (32'(table_width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = 32'(MAX_WIDTH);
      end else begin
         eff_w = 32'(table_width_ff);
      end
      if (table_height_ff == 7'd0) begin
         eff_h = 32'd1;
      end else if (32'(table_height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = 32'(MAX_HEIGHT);
      end else begin
         eff_h = 32'(table_height_ff);
      end
      last_x = XW'(eff_w - 32'd1);
      last_y = YW'(eff_h - 32'd1);
      hi_x   = POS_W'({last_x, 16'h0000});
      hi_y   = POS_W'({last_y, 16'h0000});
   end

   always_comb begin
      if (pos_x4_ff[POS_W-1]) begin
         clamp_x = '0;
      end else if (pos_x4_ff > hi_x) begin
         clamp_x = hi_x;
      end else begin
         clamp_x = pos_x4_ff;
      end
      if (pos_y4_ff[POS_W-1]) begin
         clamp_y = '0;
      end else if (pos_y4_ff > hi_y) begin
         clamp_y = hi_y;
      end else begin
         clamp_y = pos_y4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff    <= req_opcode;
         col1_ff   <= req_entry_col;
         row1_ff   <= req_entry_row;
         val1_ff   <= req_entry_value;
         neg_x1_ff <= diff_x_in[32];
         neg_y1_ff <= diff_y_in[32];
         mag_x1_ff <= mag_x_full[31:0];
         mag_y1_ff <= mag_y_full[31:0];
      end
      if (en2) begin
         op2_ff     <= op1_ff;
         col2_ff    <= col1_ff;
         row2_ff    <= row1_ff;
         val2_ff    <= val1_ff;
         neg_x2_ff  <= neg_x1_ff;
         neg_y2_ff  <= neg_y1_ff;
         prod_x2_ff <= 64'(mag_x1_ff) * 64'(inv_step_x_ff);
         prod_y2_ff <= 64'(mag_y1_ff) * 64'(inv_step_y_ff);
      end
      if (en3) begin
         op3_ff       <= op2_ff;
         col3_ff      <= col2_ff;
         row3_ff      <= row2_ff;
         val3_ff      <= val2_ff;
         scaled_x3_ff <= sv_x_in[64:16];
         scaled_y3_ff <= sv_y_in[64:16];
      end
      if (en4) begin
         op4_ff    <= op3_ff;
         col4_ff   <= col3_ff;
         row4_ff   <= row3_ff;
         val4_ff   <= val3_ff;
         pos_x4_ff <= pos_x_in;
         pos_y4_ff <= pos_y_in;
      end
      if (en5) begin
         op5_ff  <= op4_ff;
         col5_ff <= col4_ff;
         row5_ff <= row4_ff;
         val5_ff <= val4_ff;
         cx5_ff  <= clamp_x[16 +: XW];
         cy5_ff  <= clamp_y[16 +: YW];
         fx5_ff  <= clamp_x[15:0];
         fy5_ff  <= clamp_y[15:0];
      end
   end

   // parity banks: bank index is {row[0], col[0]}
   always_comb begin
      logic [XW-1:0] col_b;
      logic [YW-1:0] row_b;
      cx1 = (cx5_ff == last_x) ? cx5_ff : cx5_ff + XW'(1);
      cy1 = (cy5_ff == last_y) ? cy5_ff : cy5_ff + YW'(1);
      for (int b = 0; b < 4; b++) begin
         col_b    = (cx5_ff[0] == b[0]) ? cx5_ff : cx1;
         row_b    = (cy5_ff[0] == b[1]) ? cy5_ff : cy1;
         raddr[b] = AW'(32'(row_b >> 1) * 32'(HW) + 32'(col_b >> 1));
      end
      wcol  = XW'(col5_ff);
      wrow  = YW'(row5_ff);
      waddr = AW'(32'(wrow >> 1) * 32'(HW) + 32'(wcol >> 1));
      wr_ok = v5_ff && (op5_ff == OP_WRITE) && en6
              && (32'(col5_ff) < 32'(MAX_WIDTH)) && (32'(row5_ff) < 32'(MAX_HEIGHT));
      for (int b = 0; b < 4; b++) begin
         wr_en[b] = wr_ok && ({wrow[0], wcol[0]} == 2'(b));
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (wr_en[b]) begin
            mem[b][waddr] <= val5_ff;
         end
         if (en6) begin
            rd_ff[b] <= mem[b][raddr[b]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         sx0_ff <= cx5_ff[0];
         sx1_ff <= cx1[0];
         sy0_ff <= cy5_ff[0];
         sy1_ff <= cy1[0];
         fx6_ff <= fx5_ff;
         fy6_ff <= fy5_ff;
      end
   end

   // corners in order: lower-lower, upper-lower, lower-upper, upper-upper
   always_comb begin
      logic [16:0] wx0, wx1, wy0, wy1;
      logic [33:0] t0, t1, t2, t3;
      e_in[0] = rd_ff[{sy0_ff, sx0_ff}];
      e_in[1] = rd_ff[{sy0_ff, sx1_ff}];
      e_in[2] = rd_ff[{sy1_ff, sx0_ff}];
      e_in[3] = rd_ff[{sy1_ff, sx1_ff}];
      wx1 = {1'b0, fx6_ff};
      wy1 = {1'b0, fy6_ff};
      wx0 = Q16_ONE - wx1;
      wy0 = Q16_ONE - wy1;
      t0  = 34'(wx0) * 34'(wy0);
      t1  = 34'(wx1) * 34'(wy0);
      t2  = 34'(wx0) * 34'(wy1);
      t3  = 34'(wx1) * 34'(wy1);
      w_in[0] = t0[32:0];
      w_in[1] = t1[32:0];
      w_in[2] = t2[32:0];
      w_in[3] = t3[32:0];
   end

   always_comb begin
      logic signed [ACC_W-1:0] prod;
      for (int i = 0; i < 4; i++) begin
         prod    = $signed(e7_ff[i]) * $signed({1'b0, w7_ff[i]});
         p_in[i] = prod;
      end
   end

   // round half up, then saturate to q16.16
   always_comb begin
      acc_in = s01_ff + s23_ff + ROUND_HALF;
      fits   = (&acc10_ff[ACC_W-1:63]) || !(|acc10_ff[ACC_W-1:63]);
      if (fits) begin
         offset_in = acc10_ff[63:32];
      end else if (acc10_ff[ACC_W-1]) begin
         offset_in = Q16_MIN;
      end else begin
         offset_in = Q16_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en7) begin
         e7_ff <= e_in;
         w7_ff <= w_in;
      end
      if (en8) begin
         p8_ff <= p_in;
      end
      if (en9) begin
         s01_ff <= p8_ff[0] + p8_ff[1];
         s23_ff <= p8_ff[2] + p8_ff[3];
      end
      if (en10) begin
         acc10_ff <= acc_in;
      end
      if (en_out) begin
         rsp_offset_ff <= offset_in;
      end
   end

endmodule

// ===== dv/tb_bilinear_table_distortion_offset_core.sv =====
// ----------------------------------------------------------------------------
// tb_bilinear_table_distortion_offset_core
// self-checking bench for the bilinear distortion offset table: fills the
// offset table through write words, reprograms the axis mapping between
// phases and compares every interpolated offset with a bit-exact predictor
// ----------------------------------------------------------------------------
module tb_bilinear_table_distortion_offset_core
   import btdo_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   function automatic int used_size(logic [6:0] r, int limit);
      if (r == 0) return 1;
      if (r > limit) return limit;
      return int'(r);
   endfunction

   class offset_scoreboard_type;
      logic signed [31:0] origin_x, origin_y, base_x, base_y;
      logic [31:0]        step_x, step_y;
      logic [6:0]         width_reg, height_reg;
      logic signed [31:0] entries [0:4095];
      logic signed [31:0] offsets_due [$];
      int                 errors;

      function new();
         origin_x   = '0;
         origin_y   = '0;
         step_x     = INV_STEP_RESET;
         step_y     = INV_STEP_RESET;
         base_x     = '0;
         base_y     = '0;
         width_reg  = SIZE_RESET;
         height_reg = SIZE_RESET;
         errors     = 0;
         foreach (entries[i]) entries[i] = '0;
      endfunction

      function void set_reg(logic [3:0] idx, logic [31:0] data);
         case (idx)
            CSR_REF_COORD_X:  origin_x   = data;
            CSR_REF_COORD_Y:  origin_y   = data;
            CSR_INV_STEP_X:   step_x     = data;
            CSR_INV_STEP_Y:   step_y     = data;
            CSR_REF_INDEX_X:  base_x     = data;
            CSR_REF_INDEX_Y:  base_y     = data;
            CSR_TABLE_WIDTH:  width_reg  = data[6:0];
            CSR_TABLE_HEIGHT: height_reg = data[6:0];
            default: ;
         endcase
      endfunction

      // clamped table position of one coordinate, split into cell and fraction
      function void place(logic signed [31:0] coord, origin, logic [31:0] step,
                          logic signed [31:0] base, int size,
                          output int whole, output int frac);
         logic signed [71:0] diff, scale, pos, top;
         diff  = coord;
         pos   = origin;
         diff  = diff - pos;
         scale = {40'd0, step};
         pos   = base;
         pos   = ((diff * scale) >>> 16) + pos;
         top   = size - 1;
         top   = top <<< 16;
         if (pos < 0) pos = 0;
         if (pos > top) pos = top;
         whole = int'(pos[21:16]);
         frac  = int'(pos[15:0]);
      endfunction

      function void note_req(logic op, logic [5:0] col, row, logic signed [31:0] val,
                             logic signed [31:0] cx, cy);
         int w, h, px, fx, py, fy, px1, py1;
         logic signed [71:0] v00, v10, v01, v11, wx0, wx1, wy0, wy1, acc;
         if (op == OP_WRITE) begin
            entries[{row, col}] = val;
            return;
         end
         w = used_size(width_reg, MAX_WIDTH_DEF);
         h = used_size(height_reg, MAX_HEIGHT_DEF);
         place(cx, origin_x, step_x, base_x, w, px, fx);
         place(cy, origin_y, step_y, base_y, h, py, fy);
         px1 = (px + 1 < w) ? px + 1 : w - 1;
         py1 = (py + 1 < h) ? py + 1 : h - 1;
         v00 = entries[py * 64 + px];
         v10 = entries[py * 64 + px1];
         v01 = entries[py1 * 64 + px];
         v11 = entries[py1 * 64 + px1];
         wx1 = fx;
         wx0 = 65536 - fx;
         wy1 = fy;
         wy0 = 65536 - fy;
         acc = v00 * wx0 * wy0 + v10 * wx1 * wy0 + v01 * wx0 * wy1 + v11 * wx1 * wy1;
         // nearest, ties toward plus infinity
         acc = (acc + (72'sd1 <<< 31)) >>> 32;
         if (acc > 72'sd2147483647) acc = 72'sd2147483647;
         else if (acc < -72'sd2147483648) acc = -72'sd2147483648;
         offsets_due.push_back(acc[31:0]);
      endfunction

      function void check_rsp(logic signed [31:0] got);
         logic signed [31:0] want;
         if (offsets_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: offset word 0x%08h with none expected", $realtime, got);
            return;
         end
         want = offsets_due.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("%0t: offset mismatch, expected 0x%08h (%0d), got 0x%08h (%0d)",
                        $realtime, want, want, got, got);
         end
      endfunction
   endclass

   typedef enum int {STALL_NONE, STALL_SPARSE, STALL_COMB, STALL_HEAVY} stall_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_opcode = OP_WRITE;
   logic [5:0]         req_entry_col = '0;
   logic [5:0]         req_entry_row = '0;
   logic signed [31:0] req_entry_value = '0;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_offset;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [3:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   offset_scoreboard_type sb = new();

   bit          written [0:4095];
   int          burst_left = 0;
   int          phase_w = 1, phase_h = 1;
   int unsigned span_x = 0, span_y = 0;
   logic [3:0]  csr_idx_q [$];
   logic [31:0] csr_data_q [$];
   stall_mode_type stall_mode = STALL_NONE;
   int          stall_left = 0;

   bilinear_table_distortion_offset_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_entry_col   (req_entry_col),
      .req_entry_row   (req_entry_row),
      .req_entry_value (req_entry_value),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_offset      (rsp_offset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver: check each accepted offset word, stall in changing patterns
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_rsp(rsp_offset);
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_COMB:   rsp_stall <= stall_left[2];
         default:      rsp_stall <= ($urandom_range(0, 4) < 3);
      endcase
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned span_for(int size, logic [31:0] step);
      longint unsigned s;
      if (step == 0) return 32'h7FFF_FFFF;
      s = ((longint'(size) + 2) << 32) / step;
      if (s > 64'h7FFF_FFFF) s = 64'h7FFF_FFFF;
      return 32'(s);
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 9))
         0:       return 32'h0;
         1, 2:    return $urandom;
         default: return $urandom_range(1 << 13, 1 << 19);
      endcase
   endfunction

   task automatic send_word(logic op, logic [5:0] col, row, logic [31:0] val, cx, cy);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_col   <= col;
      req_entry_row   <= row;
      req_entry_value <= val;
      req_coord_x     <= cx;
      req_coord_y     <= cy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_req(op, col, row, val, cx, cy);
      if (op == OP_WRITE) written[{row, col}] = 1'b1;
      burst_left--;
   endtask

   // let the pipeline drain, writes included
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.offsets_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_flush();
      while (csr_idx_q.size() != 0) begin
         csr_valid <= 1'b1;
         csr_index <= csr_idx_q[0];
         csr_data  <= csr_data_q[0];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_reg(csr_idx_q.pop_front(), csr_data_q.pop_front());
      end
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(logic [31:0] ocx, ocy, stx, sty, bix, biy, logic [6:0] w, h);
      wait_idle();
      // unmapped index first, must be ignored
      csr_idx_q.push_back(4'($urandom_range(8, 15)));
      csr_data_q.push_back($urandom);
      csr_idx_q.push_back(CSR_REF_COORD_X);  csr_data_q.push_back(ocx);
      csr_idx_q.push_back(CSR_REF_COORD_Y);  csr_data_q.push_back(ocy);
      csr_idx_q.push_back(CSR_INV_STEP_X);   csr_data_q.push_back(stx);
      csr_idx_q.push_back(CSR_INV_STEP_Y);   csr_data_q.push_back(sty);
      csr_idx_q.push_back(CSR_REF_INDEX_X);  csr_data_q.push_back(bix);
      csr_idx_q.push_back(CSR_REF_INDEX_Y);  csr_data_q.push_back(biy);
      csr_idx_q.push_back(CSR_TABLE_WIDTH);  csr_data_q.push_back({25'd0, w});
      csr_idx_q.push_back(CSR_TABLE_HEIGHT); csr_data_q.push_back({25'd0, h});
      csr_flush();
      phase_w = used_size(w, MAX_WIDTH_DEF);
      phase_h = used_size(h, MAX_HEIGHT_DEF);
      span_x  = span_for(phase_w, stx);
      span_y  = span_for(phase_h, sty);
   endtask

   task automatic random_config();
      logic [6:0] w, h;
      w = 7'($urandom_range(1, 12));
      h = 7'($urandom_range(1, 12));
      set_config($urandom, $urandom, pick_step(), pick_step(),
                 $urandom_range(0, {w, 16'h0}), $urandom_range(0, {h, 16'h0}), w, h);
   endtask

   task automatic random_item();
      int          pick;
      logic [5:0]  col, row;
      logic [31:0] cx, cy;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         if ($urandom_range(0, 9) < 7) begin
            col = 6'($urandom_range(0, phase_w - 1));
            row = 6'($urandom_range(0, phase_h - 1));
         end else begin
            col = 6'($urandom);
            row = 6'($urandom);
         end
         send_word(OP_WRITE, col, row, rand_value(), $urandom, $urandom);
      end else begin
         if (pick < 85) begin
            cx = sb.origin_x + $urandom_range(0, 2 * span_x) - span_x;
            cy = sb.origin_y + $urandom_range(0, 2 * span_y) - span_y;
         end else begin
            cx = $urandom;
            cy = $urandom;
         end
         send_word(OP_INTERP, 6'($urandom), 6'($urandom), $urandom, cx, cy);
      end
   endtask

   // every entry an interpolation can reach is written before any read
   task automatic random_phase(int n);
      for (int r = 0; r < phase_h; r++)
         for (int c = 0; c < phase_w; c++)
            if (!written[r * 64 + c])
               send_word(OP_WRITE, 6'(c), 6'(r), rand_value(), $urandom, $urandom);
      repeat (n) random_item();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset configuration: single-entry table
      send_word(OP_WRITE, 6'd0, 6'd0, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(OP_INTERP, 6'd63, 6'd63, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(OP_INTERP, 6'd0, 6'd0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);

      // 2x2 table, unit step: position equals coordinate
      set_config(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 7'd2, 7'd2);
      send_word(OP_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF, 32'h0, 32'h0);
      send_word(OP_WRITE, 6'd1, 6'd0, 32'h8000_0000, 32'h0, 32'h0);
      send_word(OP_WRITE, 6'd0, 6'd1, 32'h8000_0000, 32'h0, 32'h0);
      send_word(OP_WRITE, 6'd1, 6'd1, 32'h7FFF_FFFF, 32'h0, 32'h0);
      send_word(OP_INTERP, 6'd0, 6'd0, 32'h0, 32'h0, 32'h0);
      send_word(OP_INTERP, 6'd0, 6'd0, 32'h0, 32'h0000_8000, 32'h0000_8000);
      send_word(OP_INTERP, 6'd0, 6'd0, 32'h0, 32'h0001_0000, 32'h0001_0000);
      send_word(OP_INTERP, 6'd0, 6'd0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(OP_INTERP, 6'd0, 6'd0, 32'h0, 32'h8000_0000, 32'h8000_0000);
      send_word(OP_INTERP, 6'd0, 6'd0, 32'h0, 32'h0000_4000, 32'h0000_C000);
      // writes outside the sizes in use are kept
      send_word(OP_WRITE, 6'd63, 6'd63, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_WRITE, 6'd63, 6'd0, 32'h0, 32'h0, 32'h0);
      send_word(OP_WRITE, 6'd0, 6'd63, 32'hFFFF_FFFF, 32'h0, 32'h0);
      // write then read straight behind it
      send_word(OP_WRITE, 6'd0, 6'd0, 32'h8000_0000, 32'h0, 32'h0);
      send_word(OP_INTERP, 6'd0, 6'd0, 32'h0, 32'h0000_8000, 32'h0);
      random_phase(30);

      // extreme mapping, zero step on x
      set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 7'd64, 7'd3);
      random_phase(40);

      // zero width acts as one, full height
      set_config($urandom, $urandom, $urandom_range(1 << 14, 1 << 18),
                 $urandom_range(1 << 14, 1 << 18), $urandom_range(0, 1 << 16),
                 $urandom_range(0, 64 << 16), 7'd0, 7'd64);
      random_phase(50);

      // width above the maximum acts as the maximum
      set_config($urandom, $urandom, $urandom_range(1 << 14, 1 << 18),
                 $urandom_range(1 << 14, 1 << 18), $urandom_range(0, 64 << 16),
                 $urandom_range(0, 2 << 16), 7'd127, 7'd2);
      random_phase(50);

      repeat (6) begin
         random_config();
         random_phase(40);
      end

      set_config($urandom, $urandom, $urandom_range(1 << 15, 1 << 17),
                 $urandom_range(1 << 15, 1 << 17), $urandom_range(0, 16 << 16),
                 $urandom_range(0, 16 << 16), 7'd16, 7'd16);
      random_phase(30);

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.offsets_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== bilinear_table_distortion_offset_core.f =====
src/btdo_pkg.sv
src/bilinear_table_distortion_offset_core.sv
dv/tb_bilinear_table_distortion_offset_core.sv
